@@ hw/rtl/fcw_pkg.sv @@
// Shared types and constants for the FAT12 sector chain walker.
// Used by fcw_lba_unit and fat12_sector_chain_walker; depends on nothing.
package fcw_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);

  localparam int ADDR_W = 13;
  localparam int LBA_W  = 24;
  localparam int CL_W   = 12;
  localparam int SIC_W  = 7;
  localparam int SPC_W  = 8;
  localparam int BASE_W = 16;
  localparam int CFG_AW = 4;

  localparam logic [CL_W-1:0]  END_MARK      = 12'hFF8;
  localparam logic [SPC_W-1:0] SPC_LIMIT     = 8'd128;
  localparam logic [7:0]       BYTE_PAST_END = 8'hFF;

  localparam logic [1:0] CFG_DATA_START = 2'd0;
  localparam logic [1:0] CFG_SPC        = 2'd1;
  localparam logic [1:0] CFG_ROOT       = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_OPEN = 2'd1,
    OP_ROOT = 2'd2,
    OP_NEXT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_DECODE,
    ST_LBA_START,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t               opcode;
    logic [ADDR_W-1:0] table_address;
    logic [7:0]        table_byte;
    logic [CL_W-1:0]   start_cluster;
  } cmd_t;

  typedef struct packed {
    logic [LBA_W-1:0] sector_lba;
    logic             chain_ended;
    logic [CL_W-1:0]  cluster_now;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [CL_W-1:0]   cluster;
    logic [SIC_W-1:0]  sic;
    logic [BASE_W-1:0] base;
    logic [SPC_W-1:0]  spc;
  } lba_req_t;

  typedef struct packed {
    logic             done;
    logic [LBA_W-1:0] lba;
  } lba_rsp_t;

endpackage

@@ hw/rtl/fat12_sector_chain_walker.sv @@
// FAT12 sector chain walker top level: command sequencer, allocation table
// memory, config registers and result register. Depends on fcw_pkg, fcw_lba_unit.
//
// The block takes one command at a time and is stalled while it works on it.
// A table load, an open-root command, a root-directory advance, opening at an
// end marker and advancing an ended chain go straight to the finish state.
// Opening a file, or advancing within a cluster, waits on the sector address
// from a shift-add unit that uses one adder for nine steps and registers a
// done flag with the final sum. A cluster hop first passes through the two
// byte reads of the allocation table memory, which has a single registered
// read port, and a decode state, and ends there when the next entry is an
// end marker. A finished result sits in the output register; the block takes
// the next command only after that result has moved into it. The table is not
// cleared by reset, and entries must be loaded before a chain is walked.
module fat12_sector_chain_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  fcw_pkg::cmd_t               cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output fcw_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcw_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fcw_pkg::*;

  function automatic logic in_table(logic [ADDR_W-1:0] a);
    return {1'b0, a} < (ADDR_W+1)'(TABLE_BYTES);
  endfunction

  state_t state;
  state_t state_next;

  logic [BASE_W-1:0] data_start_lba;
  logic [SPC_W-1:0]  sectors_per_cluster;
  logic [BASE_W-1:0] root_dir_lba;

  logic [BASE_W-1:0] cur_cluster;
  logic [SIC_W-1:0]  sector_in_cluster;
  logic              in_root;
  logic              ended;

  logic [LBA_W-1:0]  res_lba;
  logic [ADDR_W-1:0] hop_idx;
  logic [7:0]        lo_byte;
  logic              lo_ok;

  logic [7:0]        table_mem [TABLE_BYTES];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] rd_addr;

  logic              cmd_accept;
  logic              rsp_free;
  logic [SPC_W-1:0]  spc_eff;
  logic [SPC_W-1:0]  sic_inc;
  logic              hop;
  logic [ADDR_W-1:0] idx_calc;
  logic [ADDR_W-1:0] hop_idx_hi;
  logic [15:0]       entry_word;
  logic [CL_W-1:0]   entry;
  logic              cur_at_end;
  logic [BASE_W-1:0] root_inc;

  lba_req_t lba_req;
  lba_rsp_t lba_rsp;

  fcw_lba_unit u_lba (
    .clk (clk),
    .rst (rst),
    .req (lba_req),
    .rsp (lba_rsp)
  );

  always_comb begin
    cmd_accept = cmd_valid && (state == ST_IDLE);
    rsp_free   = !rsp_valid || !rsp_stall;
    spc_eff    = sectors_per_cluster[SPC_W-1] ? SPC_LIMIT : sectors_per_cluster;
    sic_inc    = {1'b0, sector_in_cluster} + SPC_W'(1);
    hop        = (sic_inc >= spc_eff) || (sic_inc >= SPC_LIMIT);
    idx_calc   = {1'b0, cur_cluster[CL_W-1:0]} + {2'b00, cur_cluster[CL_W-1:1]};
    hop_idx_hi = hop_idx + ADDR_W'(1);
    entry_word = {in_table(hop_idx_hi) ? rdata : BYTE_PAST_END,
                  lo_ok ? lo_byte : BYTE_PAST_END};
    entry      = cur_cluster[0] ? entry_word[15:4] : entry_word[CL_W-1:0];
    cur_at_end = cur_cluster >= {{(BASE_W-CL_W){1'b0}}, END_MARK};
    root_inc   = cur_cluster + BASE_W'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.opcode)
            OP_LOAD: state_next = ST_FINISH;
            OP_OPEN: state_next = (cmd.start_cluster >= END_MARK) ? ST_FINISH : ST_LBA_START;
            OP_ROOT: state_next = ST_FINISH;
            OP_NEXT: begin
              priority if (in_root || ended) begin
                state_next = ST_FINISH;
              end else if (hop) begin
                state_next = ST_FETCH_LO;
              end else if (cur_at_end) begin
                state_next = ST_FINISH;
              end else begin
                state_next = ST_LBA_START;
              end
            end
          endcase
        end
      end
      ST_FETCH_LO:  state_next = ST_FETCH_HI;
      ST_FETCH_HI:  state_next = ST_DECODE;
      ST_DECODE:    state_next = (entry >= END_MARK) ? ST_FINISH : ST_LBA_START;
      ST_LBA_START: state_next = ST_MUL;
      ST_MUL:       state_next = lba_rsp.done ? ST_FINISH : ST_MUL;
      ST_FINISH:    state_next = rsp_free ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_stall       = (state != ST_IDLE);
    rd_addr         = (state == ST_FETCH_HI) ? hop_idx_hi : hop_idx;
    lba_req.start   = (state == ST_LBA_START);
    lba_req.cluster = cur_cluster[CL_W-1:0];
    lba_req.sic     = sector_in_cluster;
    lba_req.base    = data_start_lba;
    lba_req.spc     = spc_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cur_cluster       <= '0;
      sector_in_cluster <= '0;
      in_root           <= 1'b0;
      ended             <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_accept) begin
        unique case (cmd.opcode)
          OP_LOAD: ;
          OP_OPEN: begin
            cur_cluster       <= {{(BASE_W-CL_W){1'b0}}, cmd.start_cluster};
            sector_in_cluster <= '0;
            in_root           <= 1'b0;
            ended             <= cmd.start_cluster >= END_MARK;
          end
          OP_ROOT: begin
            cur_cluster       <= root_dir_lba;
            sector_in_cluster <= '0;
            in_root           <= 1'b1;
            ended             <= 1'b0;
          end
          OP_NEXT: begin
            priority if (in_root) begin
              cur_cluster <= root_inc;
            end else if (!ended) begin
              if (hop) begin
                sector_in_cluster <= '0;
              end else begin
                sector_in_cluster <= sic_inc[SIC_W-1:0];
                ended             <= cur_at_end;
              end
            end else begin
            end
          end
        endcase
      end else if (state == ST_DECODE) begin
        cur_cluster <= {{(BASE_W-CL_W){1'b0}}, entry};
        ended       <= entry >= END_MARK;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        hop_idx <= idx_calc;
        if (cmd_valid && cmd.opcode == OP_ROOT) begin
          res_lba <= {{(LBA_W-BASE_W){1'b0}}, root_dir_lba};
        end else if (cmd_valid && cmd.opcode == OP_NEXT && in_root) begin
          res_lba <= {{(LBA_W-BASE_W){1'b0}}, root_inc};
        end else begin
          res_lba <= '0;
        end
      end
      ST_FETCH_HI: begin
        lo_byte <= rdata;
        lo_ok   <= in_table(hop_idx);
      end
      ST_DECODE: res_lba <= '0;
      ST_MUL: begin
        if (lba_rsp.done) begin
          res_lba <= lba_rsp.lba;
        end
      end
      ST_FETCH_LO, ST_LBA_START, ST_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_accept && cmd.opcode == OP_LOAD && in_table(cmd.table_address)) begin
      table_mem[cmd.table_address[TABLE_AW-1:0]] <= cmd.table_byte;
    end
    rdata <= table_mem[rd_addr[TABLE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_FINISH && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && rsp_free) begin
      rsp.sector_lba  <= res_lba;
      rsp.chain_ended <= ended;
      rsp.cluster_now <= cur_cluster[CL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_start_lba      <= BASE_W'(33);
      sectors_per_cluster <= SPC_W'(1);
      root_dir_lba        <= BASE_W'(19);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        CFG_DATA_START: data_start_lba      <= pwdata[BASE_W-1:0];
        CFG_SPC:        sectors_per_cluster <= pwdata[SPC_W-1:0];
        CFG_ROOT:       root_dir_lba        <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pready = 1'b1;
    case (paddr[3:2])
      CFG_DATA_START: prdata = {{(32-BASE_W){1'b0}}, data_start_lba};
      CFG_SPC:        prdata = {{(32-SPC_W){1'b0}}, sectors_per_cluster};
      CFG_ROOT:       prdata = {{(32-BASE_W){1'b0}}, root_dir_lba};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/fcw_lba_unit.sv @@
// Shift-add sector address unit: base + (cluster - 2) * spc + sic, modulo 2^24.
// One shared 24-bit adder, one step per cycle. Depends on fcw_pkg.
module fcw_lba_unit (
  input  logic             clk,
  input  logic             rst,
  input  fcw_pkg::lba_req_t req,
  output fcw_pkg::lba_rsp_t rsp
);
  import fcw_pkg::*;

  localparam int STEP_W = $clog2(SPC_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [LBA_W-1:0]  acc;
  logic [LBA_W-1:0]  mcand;
  logic [SPC_W-1:0]  mplier;
  logic [SIC_W-1:0]  sic_hold;
  logic [LBA_W-1:0]  addend;
  logic [LBA_W-1:0]  sum;

  always_comb begin
    if (step == '0) begin
      addend = {{(LBA_W-SIC_W){1'b0}}, sic_hold};
    end else if (mplier[0]) begin
      addend = mcand;
    end else begin
      addend = '0;
    end
    sum = acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == STEP_W'(SPC_W));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SPC_W)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc      <= {{(LBA_W-BASE_W){1'b0}}, req.base};
      mcand    <= {{(LBA_W-CL_W){1'b0}}, req.cluster} - LBA_W'(2);
      mplier   <= req.spc;
      sic_hold <= req.sic;
    end else if (busy) begin
      acc <= sum;
      if (step != '0) begin
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.lba  = acc;

endmodule
